// ===== rtl/core/lmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmg_pkg: shared types and constants of the minimal standard generator
// Widths of the request and result fields, the generator constants and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package lmg_pkg;

  localparam int SEED_W    = 31;
  localparam int VALUE_W   = 32;
  localparam int SHIFT_W   = 6;
  localparam int MULT_W    = 15;
  localparam int PRODUCT_W = SEED_W + MULT_W;
  localparam int QUOT_W    = PRODUCT_W - SEED_W;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [MULT_W-1:0] LCG_MULT   = 15'd16807;
  localparam logic [SEED_W-1:0] LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd1;

  // Request function codes.
  localparam logic FUNC_GENERATE = 1'b0;
  localparam logic FUNC_LOAD     = 1'b1;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_SHIFT_BITS = 1'b0;

  typedef logic signed [SHIFT_W-1:0] shift_t;
  typedef logic        [SEED_W-1:0]  seed_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// ===== rtl/core/lmg_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmg_req_if: request channel of the generator
// Carries the function code and the seed for a load request.
// ----------------------------------------------------------------------------
interface lmg_req_if import lmg_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  seed_t seed_value;

  modport source (output valid, output func, output seed_value, input ready);
  modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// ===== rtl/core/lmg_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmg_res_if: result channel of the generator
// Carries one generated value per generate request.
// ----------------------------------------------------------------------------
interface lmg_res_if import lmg_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/core/lmg_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmg_step: one step of the generator
// Multiplies the seed by 16807, folds the product modulo 2^31-1 and
// forms the output value from the new seed and the quotient bit.
// ----------------------------------------------------------------------------
module lmg_step import lmg_pkg::*; (
  input  seed_t  seed,
  input  shift_t shift_bits,
  output seed_t  seed_next,
  output value_t value
);

  logic [PRODUCT_W-1:0] prod;
  logic [QUOT_W-1:0]    quot;
  logic [SEED_W:0]      sum;
  logic                 over;
  logic                 quot_bit;
  logic [VALUE_W-1:0]   mag;

  assign prod = PRODUCT_W'(seed) * PRODUCT_W'(LCG_MULT);
  assign quot = prod[PRODUCT_W-1:SEED_W];
  assign sum  = {1'b0, prod[SEED_W-1:0]} + (SEED_W + 1)'(quot);

  // 2^31 = 1 mod (2^31-1), so the quotient folds back in as a plain add.
  // A sum equal to the modulus is left alone.
  assign over      = sum > {1'b0, LCG_MOD};
  assign seed_next = over ? SEED_W'(sum - {1'b0, LCG_MOD}) : sum[SEED_W-1:0];
  assign quot_bit  = quot[0] ^ over;

  assign mag = VALUE_W'(seed_next);

  always_comb begin
    if (!shift_bits[SHIFT_W-1]) begin
      value = value_t'(mag >> shift_bits[SHIFT_W-2:0]);
    end else if (quot_bit) begin
      value = value_t'(VALUE_W'(0) - mag);
    end else begin
      value = value_t'(mag);
    end
  end

endmodule

// ===== rtl/core/lehmer_minstd_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_minstd_generator: minimal standard Lehmer random number generator
// Seed update r <= r*16807 mod (2^31-1), with shifted or signed output.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req. A generate request (func 0) advances the seed
// and returns one value on res; a load request (func 1) replaces the seed
// with seed_value and returns nothing. Results leave in request order.
// A request is registered on acceptance; when it leaves the request
// register, the step unit (constant multiply, fold and conditional
// subtract) updates the seed and loads the output register, which
// holds the value on res until it is taken. One request per cycle is
// taken in steady state while res does not stall; the seed feedback
// through the step unit sets that rate.
// When res stalls, the output register holds its value and the request
// register fills; req.ready then drops until the result is taken. Load
// requests pass through even while the output is stalled.
// shift_bits (address 0) selects a right shift of 0 to 31, or, when
// negative, signed output using the quotient bit. Reset sets the seed to
// 1 and shift_bits to 0 and empties both registers. pready is always high.
// ----------------------------------------------------------------------------
module lehmer_minstd_generator import lmg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  lmg_req_if.sink            req,
  lmg_res_if.source          res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  shift_t shift_bits;
  seed_t  seed;
  seed_t  seed_next;

  logic   s1_valid;
  logic   s1_func;
  seed_t  s1_seed;
  logic   s1_advance;

  logic   out_valid;
  value_t out_value;

  seed_t  step_seed;
  value_t step_value;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = PDATA_W'($unsigned(shift_bits));

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_SHIFT_BITS) begin
      shift_bits <= shift_t'(pwdata[SHIFT_W-1:0]);
    end
  end

  // Request register.
  assign s1_advance = s1_valid && (s1_func == FUNC_LOAD || !out_valid || res.ready);
  assign req.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_func <= req.func;
      s1_seed <= req.seed_value;
    end
  end

  lmg_step u_step (
    .seed       (seed),
    .shift_bits (shift_bits),
    .seed_next  (step_seed),
    .value      (step_value)
  );

  always_comb begin
    seed_next = seed;
    if (s1_advance) begin
      seed_next = (s1_func == FUNC_LOAD) ? s1_seed : step_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else begin
      seed <= seed_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_func == FUNC_GENERATE) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_func == FUNC_GENERATE) begin
      out_value <= step_value;
    end
  end

  assign res.valid = out_valid;
  assign res.value = out_value;

  // The seed comes out of reset at its reset value.
  a_seed_reset: assert property (@(posedge clk) $past(rst) |-> seed == SEED_RESET)
    else $error("seed not at reset value after reset");

  // The seed only moves when a request leaves the request register.
  a_seed_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(seed))
    else $error("seed changed without a request");

  // A nonzero seed never steps to zero.
  a_seed_nonzero: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_func == FUNC_GENERATE && seed != '0) |=> seed != '0)
    else $error("nonzero seed stepped to zero");

  // Every generate request that leaves the request register shows a result.
  a_gen_result: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_func == FUNC_GENERATE) |=> out_valid)
    else $error("generate request lost its result");

  // A load request never produces a result on its own.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_func == FUNC_LOAD && !out_valid) |=> !out_valid)
    else $error("load request produced a result");

endmodule
